// ===== src/tlbc_pkg.sv =====
// line break classifier package: class, rule and context types, the rule table
// and the context remap function
// no dependencies
`timescale 1ns / 1ps

package tlbc_pkg;

  localparam int unsigned CodeW = 21;

  // ideographic ranges
  localparam logic [CodeW-1:0] IdeoALo = 21'h003000;
  localparam logic [CodeW-1:0] IdeoAHi = 21'h0030FF;
  localparam logic [CodeW-1:0] IdeoBLo = 21'h004E00;
  localparam logic [CodeW-1:0] IdeoBHi = 21'h009FAF;
  localparam logic [CodeW-1:0] IdeoCLo = 21'h00AC00;
  localparam logic [CodeW-1:0] IdeoCHi = 21'h00D7AF;
  localparam logic [CodeW-1:0] IdeoDLo = 21'h00FF00;
  localparam logic [CodeW-1:0] IdeoDHi = 21'h00FFEF;
  localparam logic [CodeW-1:0] IdeoELo = 21'h01B000;
  localparam logic [CodeW-1:0] IdeoEHi = 21'h01B16F;

  localparam logic [1:0] PriNone = 2'd0;
  localparam logic [1:0] PriLow = 2'd1;
  localparam logic [1:0] PriOpp = 2'd2;
  localparam logic [1:0] PriForced = 2'd3;

  typedef enum logic [3:0] {
    CLS_CR, CLS_LF, CLS_SP, CLS_AL, CLS_IS, CLS_CL, CLS_OP,
    CLS_ID, CLS_CJ, CLS_NS, CLS_NU, CLS_PO, CLS_PR, CLS_SY
  } cls_e;

  typedef enum logic [2:0] {
    TRG_NEUTRAL, TRG_OPP, TRG_FORCE, TRG_PROHIBIT, TRG_PROHIBIT_UAS, TRG_LOW
  } trig_e;

  typedef enum logic [1:0] {
    CTX_UNDEF, CTX_TEXT, CTX_NUM
  } ctx_e;

  typedef struct packed {
    trig_e lead;
    trig_e trail;
    logic  is_space;
    logic  more_space;
    ctx_e  ctx;
  } rule_t;

  function automatic rule_t rule_of(cls_e c);
    rule_t r;
    case (c)
      CLS_CR:  r = '{TRG_NEUTRAL,      TRG_NEUTRAL,  1'b1, 1'b0, CTX_UNDEF};
      CLS_LF:  r = '{TRG_OPP,          TRG_FORCE,    1'b1, 1'b0, CTX_UNDEF};
      CLS_SP:  r = '{TRG_OPP,          TRG_OPP,      1'b1, 1'b1, CTX_UNDEF};
      CLS_AL:  r = '{TRG_NEUTRAL,      TRG_NEUTRAL,  1'b0, 1'b0, CTX_TEXT};
      CLS_IS:  r = '{TRG_NEUTRAL,      TRG_NEUTRAL,  1'b0, 1'b0, CTX_UNDEF};
      CLS_CL:  r = '{TRG_PROHIBIT,     TRG_OPP,      1'b0, 1'b0, CTX_UNDEF};
      CLS_OP:  r = '{TRG_OPP,          TRG_PROHIBIT, 1'b0, 1'b0, CTX_UNDEF};
      CLS_ID:  r = '{TRG_LOW,          TRG_LOW,      1'b0, 1'b0, CTX_TEXT};
      CLS_CJ:  r = '{TRG_PROHIBIT_UAS, TRG_LOW,      1'b0, 1'b0, CTX_TEXT};
      CLS_NS:  r = '{TRG_PROHIBIT_UAS, TRG_LOW,      1'b0, 1'b0, CTX_TEXT};
      CLS_NU:  r = '{TRG_NEUTRAL,      TRG_NEUTRAL,  1'b0, 1'b0, CTX_NUM};
      CLS_PO:  r = '{TRG_PROHIBIT,     TRG_OPP,      1'b0, 1'b0, CTX_UNDEF};
      CLS_PR:  r = '{TRG_OPP,          TRG_PROHIBIT, 1'b0, 1'b0, CTX_UNDEF};
      CLS_SY:  r = '{TRG_NEUTRAL,      TRG_OPP,      1'b0, 1'b0, CTX_UNDEF};
      default: r = '{TRG_NEUTRAL,      TRG_NEUTRAL,  1'b0, 1'b0, CTX_UNDEF};
    endcase
    return r;
  endfunction

  // separators close in text, slash is numeric in numeric context
  function automatic cls_e remap(cls_e c, ctx_e x);
    cls_e r;
    r = c;
    if (c == CLS_IS && x == CTX_TEXT) r = CLS_CL;
    if (c == CLS_SY && x == CTX_NUM) r = CLS_NU;
    return r;
  endfunction

endpackage

// ===== src/text_line_break_classifier_top.sv =====
// line break classifier top level: input register, classification and rule
// logic, context register and result register
// depends on tlbc_pkg and tlbc_classify
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid_i / in_ready_o carry one request, a pair of code
// points (cur_code_i, next_code_i). Output channel: out_valid_o / out_ready_i
// carry one result per request: break priority and the space flags.
// Path: an accepted request is loaded into the input register, then into the
// result register when that is empty or its result is taken. Throughput: one
// request per cycle unless stalled; classification and the rule table sit
// between the input register and the result register, and the text/numeric
// context register is updated as each request moves into the result register.
// Reset: both stages empty, context undefined.
// Stall: while the result is not taken, the result register holds, the input
// register still takes one request and then in_ready_o falls until the
// result moves on.
module text_line_break_classifier_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tlbc_pkg::CodeW-1:0] cur_code_i,
  input  logic [tlbc_pkg::CodeW-1:0] next_code_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 break_priority_o,
  output logic                       trim_present_o,
  output logic                       forced_break_o,
  output logic                       at_whitespace_o,
  output logic                       absorb_more_space_o
);
  import tlbc_pkg::*;

  logic             in_vld_q;
  logic [CodeW-1:0] cur_q;
  logic [CodeW-1:0] nxt_q;
  logic             out_vld_q;
  ctx_e             ctx_q;
  ctx_e             ctx_d;

  logic [1:0] pri_q, pri_d;
  logic       trim_q, trim_d;
  logic       forced_q, forced_d;
  logic       ws_q, ws_d;
  logic       more_q, more_d;

  cls_e  cls_a;
  cls_e  cls_b;
  ctx_e  ctx_new;
  rule_t ra;
  rule_t rb;
  logic  out_load;

  tlbc_classify u_cls_cur (
    .code_i (cur_q),
    .cls_o  (cls_a)
  );

  tlbc_classify u_cls_nxt (
    .code_i (nxt_q),
    .cls_o  (cls_b)
  );

  assign out_load   = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_load;

  always_comb begin
    ra = rule_of(cls_a);
    rb = rule_of(cls_b);
    ctx_new = ra.ctx;
    if (ctx_new == CTX_UNDEF) ctx_new = rb.ctx;
    ctx_d = (ctx_new != CTX_UNDEF) ? ctx_new : ctx_q;

    ra = rule_of(remap(cls_a, ctx_d));
    rb = rule_of(remap(cls_b, ctx_d));

    pri_d    = PriNone;
    trim_d   = 1'b0;
    forced_d = 1'b0;
    ws_d     = 1'b0;
    more_d   = 1'b0;
    if (ra.trail == TRG_FORCE) begin
      pri_d    = PriForced;
      forced_d = 1'b1;
      ws_d     = 1'b1;
    end else if (ra.is_space) begin
      pri_d  = PriOpp;
      trim_d = 1'b1;
      ws_d   = 1'b1;
      more_d = ra.more_space && (cls_a == cls_b);
    end else if (ra.trail == TRG_PROHIBIT || rb.lead == TRG_PROHIBIT ||
                 rb.lead == TRG_PROHIBIT_UAS) begin
      pri_d = PriNone;
    end else if (ra.trail == TRG_OPP || rb.lead == TRG_OPP) begin
      pri_d  = PriOpp;
      trim_d = 1'b1;
    end else if (ra.trail == TRG_LOW || rb.lead == TRG_LOW) begin
      pri_d = PriLow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctx_q     <= CTX_UNDEF;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (out_load) out_vld_q <= in_vld_q;
      if (out_load && in_vld_q) ctx_q <= ctx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cur_q <= cur_code_i;
      nxt_q <= next_code_i;
    end
    if (out_load && in_vld_q) begin
      pri_q    <= pri_d;
      trim_q   <= trim_d;
      forced_q <= forced_d;
      ws_q     <= ws_d;
      more_q   <= more_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign break_priority_o    = pri_q;
  assign trim_present_o      = trim_q;
  assign forced_break_o      = forced_q;
  assign at_whitespace_o     = ws_q;
  assign absorb_more_space_o = more_q;

  // trim flag goes with an ordinary opportunity only
  a_trim_pri : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (trim_q == (pri_q == PriOpp)))
    else $error("trim flag disagrees with break priority");

  a_forced_ws : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && forced_q |-> ws_q && pri_q == PriForced)
    else $error("forced break without whitespace or forced priority");

  a_more_space : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && more_q |-> ws_q && !forced_q && pri_q == PriOpp)
    else $error("extra space absorb outside a space opportunity");

  a_ctx_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_load && in_vld_q) |=> $stable(ctx_q))
    else $error("context changed without a request moving on");

  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free stage");

endmodule

// ===== src/tlbc_classify.sv =====
// line break classifier: code point to line break class
// depends on tlbc_pkg
`timescale 1ns / 1ps

module tlbc_classify (
  input  logic [tlbc_pkg::CodeW-1:0] code_i,
  output tlbc_pkg::cls_e             cls_o
);
  import tlbc_pkg::*;

  logic ideo;

  assign ideo = (code_i >= IdeoALo && code_i <= IdeoAHi) ||
                (code_i >= IdeoBLo && code_i <= IdeoBHi) ||
                (code_i >= IdeoCLo && code_i <= IdeoCHi) ||
                (code_i >= IdeoDLo && code_i <= IdeoDHi) ||
                (code_i >= IdeoELo && code_i <= IdeoEHi);

  // first matching arm wins, so the earlier set takes a duplicated character
  always_comb begin
    case (code_i)
      21'h30, 21'h31, 21'h32, 21'h33, 21'h34,
      21'h35, 21'h36, 21'h37, 21'h38, 21'h39: cls_o = CLS_NU;
      21'h0D: cls_o = CLS_CR;
      21'h0A: cls_o = CLS_LF;
      21'h20, 21'h09, 21'h3000: cls_o = CLS_SP;
      21'h2C, 21'h2E, 21'h3B, 21'h3A: cls_o = CLS_IS;
      21'h25: cls_o = CLS_PO;
      21'h2F: cls_o = CLS_SY;
      21'h3005, 21'h301C, 21'h30FB: cls_o = CLS_NS;
      21'h3041, 21'h3043, 21'h3045, 21'h3047, 21'h3049, 21'h3063,
      21'h3083, 21'h3085, 21'h3087, 21'h308E, 21'h3095, 21'h30A1,
      21'h30A3, 21'h30A5, 21'h30A7, 21'h30A9, 21'h30C3, 21'h30E3,
      21'h30E5, 21'h30E7, 21'h30EE, 21'h30F5, 21'h30FC: cls_o = CLS_CJ;
      21'h24, 21'hA3, 21'h20AC, 21'hA5, 21'h5C: cls_o = CLS_PR;
      21'h28, 21'h5B, 21'h7B, 21'hFF08, 21'hFF5B,
      21'hFF3B, 21'h3010, 21'h300C, 21'h300E, 21'h27E8: cls_o = CLS_OP;
      21'h2D, 21'h21, 21'h3F, 21'h29, 21'h5D, 21'h7D, 21'h3001,
      21'h3002, 21'h2026, 21'h2025, 21'hFF09, 21'hFF5D, 21'hFF3D,
      21'h3011, 21'h300D, 21'h300F, 21'h27E9, 21'hFF01, 21'hFF1F: cls_o = CLS_CL;
      default: cls_o = ideo ? CLS_ID : CLS_AL;
    endcase
  end

endmodule
